/* rtl/core/tbcm_pkg.sv */
package tbcm_pkg;

  // Register map of the configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_LONG_HALF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_HALF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE  = 2'd2;

  // Register reset values
  localparam logic [3:0] LONG_HALF_RST  = 4'd4;
  localparam logic [2:0] SHORT_HALF_RST = 3'd2;
  localparam logic [6:0] AMPLITUDE_RST  = 7'd127;

  // Half-wave length limits
  localparam logic [3:0] LONG_MAX  = 4'd8;
  localparam logic [2:0] SHORT_MAX = 3'd4;

  localparam logic [7:0] MIDPOINT = 8'd128;

  // Effective settings after length clamping
  typedef struct packed {
    logic [3:0] long_len;   // 1..8
    logic [2:0] short_len;  // 1..4
    logic [6:0] amplitude;
  } cfg_t;

  // One sample handed from the sequencer to the output register
  typedef struct packed {
    logic       valid;
    logic [7:0] sample;
    logic       last;
  } emit_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_t;

endpackage

/* rtl/core/tape_bit_cell_modulator_top.sv */
// The first sample of a byte is registered in the sequencer state and then in the
// output register after the byte transfer. One sample per cycle, held by out_stall,
// from a single sample counter; a byte's 8 to 64 samples end before the next byte.
// Reset (synchronous, rst_n low): registers to defaults, polarity positive,
// sequencer idle, output register empty.
module tape_bit_cell_modulator_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_data_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_sample,
  output logic                            out_last,
  input  logic                            cfg_we,
  input  logic [tbcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tbcm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  tbcm_pkg::cfg_t  cfg;
  tbcm_pkg::emit_t emit;
  logic            busy;
  logic            advance;
  logic            out_valid_r;
  logic [7:0]      out_sample_r;
  logic            out_last_r;

  tbcm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  // Output register may load when empty or being drained
  assign advance = !out_valid_r || !out_stall;

  tbcm_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_i   (cfg),
    .start   (in_valid && !busy),
    .byte_i  (in_data_byte),
    .advance (advance),
    .busy    (busy),
    .emit_o  (emit)
  );

  assign in_stall = busy;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit.valid) begin
      out_sample_r <= emit.sample;
      out_last_r   <= emit.last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_last   = out_last_r;

endmodule

/* rtl/core/tbcm_cfg_regs.sv */
module tbcm_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tbcm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tbcm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output tbcm_pkg::cfg_t                 cfg_o
);

  logic [3:0] long_half_r;
  logic [2:0] short_half_r;
  logic [6:0] amplitude_r;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_half_r  <= tbcm_pkg::LONG_HALF_RST;
      short_half_r <= tbcm_pkg::SHORT_HALF_RST;
      amplitude_r  <= tbcm_pkg::AMPLITUDE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tbcm_pkg::CFG_LONG_HALF:  long_half_r  <= cfg_wdata[3:0];
        tbcm_pkg::CFG_SHORT_HALF: short_half_r <= cfg_wdata[2:0];
        tbcm_pkg::CFG_AMPLITUDE:  amplitude_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp lengths: zero counts as one, oversize to the limit
  always_comb begin
    if (long_half_r == 4'd0) begin
      cfg_o.long_len = 4'd1;
    end else if (long_half_r > tbcm_pkg::LONG_MAX) begin
      cfg_o.long_len = tbcm_pkg::LONG_MAX;
    end else begin
      cfg_o.long_len = long_half_r;
    end
    if (short_half_r == 3'd0) begin
      cfg_o.short_len = 3'd1;
    end else if (short_half_r > tbcm_pkg::SHORT_MAX) begin
      cfg_o.short_len = tbcm_pkg::SHORT_MAX;
    end else begin
      cfg_o.short_len = short_half_r;
    end
    cfg_o.amplitude = amplitude_r;
  end

endmodule

/* rtl/core/tbcm_seq.sv */
module tbcm_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tbcm_pkg::cfg_t       cfg_i,
  input  logic                 start,
  input  logic [7:0]           byte_i,
  input  logic                 advance,   // output stage can take a sample
  output logic                 busy,
  output tbcm_pkg::emit_t      emit_o
);

  tbcm_pkg::seq_state_t state_r, state_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [2:0] bit_cnt_r, bit_cnt_nxt;
  logic [2:0] smp_cnt_r, smp_cnt_nxt;
  logic       second_r, second_nxt;   // in second half-wave of a one bit
  logic       pol_r, pol_nxt;         // 0 = above midpoint

  logic       cur_bit;
  logic [3:0] len;
  logic [2:0] len_m1;
  logic       half_done, bit_done, byte_done, step;

  assign cur_bit   = shift_r[7];
  assign len       = cur_bit ? {1'b0, cfg_i.short_len} : cfg_i.long_len;
  assign len_m1    = 3'(len - 4'd1);
  assign half_done = (smp_cnt_r == len_m1);
  assign bit_done  = half_done && (!cur_bit || second_r);
  assign byte_done = bit_done && (bit_cnt_r == 3'd7);
  assign step      = (state_r == tbcm_pkg::ST_RUN) && advance;
  assign busy      = (state_r != tbcm_pkg::ST_IDLE);

  // Shared level unit: midpoint plus or minus amplitude
  always_comb begin
    emit_o.valid  = step;
    emit_o.sample = pol_r ? (tbcm_pkg::MIDPOINT - {1'b0, cfg_i.amplitude})
                          : (tbcm_pkg::MIDPOINT + {1'b0, cfg_i.amplitude});
    emit_o.last   = byte_done;
  end

  // Sequencer: sample, half-wave and bit counters
  always_comb begin
    state_nxt   = state_r;
    shift_nxt   = shift_r;
    bit_cnt_nxt = bit_cnt_r;
    smp_cnt_nxt = smp_cnt_r;
    second_nxt  = second_r;
    pol_nxt     = pol_r;
    unique case (state_r)
      tbcm_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt   = tbcm_pkg::ST_RUN;
          shift_nxt   = byte_i;
          bit_cnt_nxt = 3'd0;
          smp_cnt_nxt = 3'd0;
          second_nxt  = 1'b0;
        end
      end
      tbcm_pkg::ST_RUN: begin
        if (step) begin
          if (half_done) begin
            smp_cnt_nxt = 3'd0;
            pol_nxt     = !pol_r;
            if (bit_done) begin
              second_nxt  = 1'b0;
              shift_nxt   = {shift_r[6:0], 1'b0};
              bit_cnt_nxt = 3'(bit_cnt_r + 3'd1);
              if (byte_done) begin
                state_nxt = tbcm_pkg::ST_IDLE;
              end
            end else begin
              second_nxt = 1'b1;
            end
          end else begin
            smp_cnt_nxt = 3'(smp_cnt_r + 3'd1);
          end
        end
      end
      default: state_nxt = tbcm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tbcm_pkg::ST_IDLE;
      pol_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pol_r   <= pol_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r   <= shift_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    smp_cnt_r <= smp_cnt_nxt;
    second_r  <= second_nxt;
  end

endmodule
